>>> src/rfsh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfsh_pkg
// Shared sizes, register and mode codes, and types of the range filtered
// sample history.
// ----------------------------------------------------------------------------
package rfsh_pkg;

	localparam int HISTORY_DEPTH = 64;
	localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
	localparam int COUNT_W       = $clog2(HISTORY_DEPTH + 1);
	localparam int VALUE_W       = 16;
	localparam int TIME_W        = 64;
	localparam int READ_COUNT_W  = 7;
	localparam int PADDR_W       = 3;
	localparam int PDATA_W       = 32;

	localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);
	localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(HISTORY_DEPTH);

	localparam logic REG_VALUE_MINIMUM = 1'b0;
	localparam logic REG_VALUE_MAXIMUM = 1'b1;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_READ = 1'b1;

	localparam logic signed [VALUE_W-1:0] VALUE_MINIMUM_RST = 16'sh8000;
	localparam logic signed [VALUE_W-1:0] VALUE_MAXIMUM_RST = 16'sh7fff;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic signed [TIME_W-1:0]  stamp;
	} ring_entry_t;

	typedef struct packed {
		ring_entry_t entry;
		logic        last;
	} result_t;

	typedef struct packed {
		logic              wr_en;
		logic [SLOT_W-1:0] wr_slot;
		logic              rd_en;
		logic [SLOT_W-1:0] rd_slot;
	} ring_ctrl_t;

	typedef enum logic {
		WALK_IDLE,
		WALK_RUN
	} walk_state_t;

endpackage
`default_nettype wire

>>> src/rfsh_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfsh_ring
// History storage: one synchronous memory holding sample and timestamp per
// slot, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rfsh_ring
	import rfsh_pkg::*;
(
	input  wire logic        clk,
	input  wire ring_ctrl_t  ctrl,
	input  wire ring_entry_t wr_entry,
	output ring_entry_t      rd_entry
);

	ring_entry_t ring_q [HISTORY_DEPTH];
	ring_entry_t rd_entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			ring_q[ctrl.wr_slot] <= wr_entry;
		end
		if (ctrl.rd_en) begin
			rd_entry_q <= ring_q[ctrl.rd_slot];
		end
	end

	assign rd_entry = rd_entry_q;

endmodule
`default_nettype wire

>>> src/range_filtered_sample_history_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// range_filtered_sample_history_top
// Ring of the most recent in-range samples with timestamps, read back
// newest first.
// ----------------------------------------------------------------------------
// A push is accepted whenever the block is idle, and written straight
// into the ring memory if it lies within the configured range, so pushes
// may follow each other every cycle. A read of n entries (n = min(read_count,
// number held)) keeps the input channel closed while the walker reads n ring
// slots, one per cycle while the two-entry output buffer has room, through
// the single memory read port, so out_ready holding results back keeps it
// closed longer. Each result passes through the ring read register into the
// output buffer and leaves one per cycle while out_ready stays high. Reads
// and writes of the ring never overlap, since writes happen only while idle.
// The last result of each run carries last_entry.
// ----------------------------------------------------------------------------
module range_filtered_sample_history_top
	import rfsh_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [PADDR_W-1:0]        paddr,
	input  wire logic [PDATA_W-1:0]        pwdata,
	output logic [PDATA_W-1:0]             prdata,
	output logic                           pready,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      mode,
	input  wire logic signed [VALUE_W-1:0] sample,
	input  wire logic signed [TIME_W-1:0]  sample_time,
	input  wire logic [READ_COUNT_W-1:0]   read_count,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic signed [VALUE_W-1:0]      stored_value,
	output logic signed [TIME_W-1:0]       stored_time,
	output logic                           last_entry
);

	logic signed [VALUE_W-1:0] min_q;
	logic signed [VALUE_W-1:0] max_q;
	logic                      cfg_wr;

	logic [SLOT_W-1:0]         newest_q;
	logic [COUNT_W-1:0]        count_q;
	logic [SLOT_W-1:0]         next_slot;
	logic                      push_acc;
	logic                      read_acc;
	logic                      store;
	logic [READ_COUNT_W-1:0]   count_ext;
	logic [READ_COUNT_W-1:0]   run_len;

	walk_state_t               state_q;
	walk_state_t               state_d;
	logic [SLOT_W-1:0]         slot_q;
	logic [READ_COUNT_W-1:0]   remain_q;
	logic                      issue;
	logic                      credit;

	logic                      rd_vld_s1;
	logic                      last_s1;
	ring_ctrl_t                ring_ctrl;
	ring_entry_t               wr_entry;
	ring_entry_t               rd_entry;

	result_t                   fifo_q [2];
	logic                      wr_ptr_q;
	logic                      rd_ptr_q;
	logic [1:0]                occ_q;
	logic                      pop;
	logic [2:0]                pending;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= VALUE_MINIMUM_RST;
			max_q <= VALUE_MAXIMUM_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_VALUE_MINIMUM: min_q <= pwdata[VALUE_W-1:0];
				REG_VALUE_MAXIMUM: max_q <= pwdata[VALUE_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_VALUE_MINIMUM: prdata = {{(PDATA_W-VALUE_W){1'b0}}, min_q};
			REG_VALUE_MAXIMUM: prdata = {{(PDATA_W-VALUE_W){1'b0}}, max_q};
		endcase
	end

	// push path
	assign push_acc  = in_valid & in_ready & (mode == MODE_PUSH);
	assign read_acc  = in_valid & in_ready & (mode == MODE_READ);
	assign store     = push_acc & (sample >= min_q) & (sample <= max_q);
	assign next_slot = (newest_q == SLOT_LAST) ? '0 : newest_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q <= '0;
			count_q  <= '0;
		end else if (store) begin
			newest_q <= next_slot;
			if (count_q != COUNT_FULL) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// read walker
	assign count_ext = READ_COUNT_W'(count_q);
	assign run_len   = (read_count < count_ext) ? read_count : count_ext;
	assign pending   = 3'(occ_q) + 3'(rd_vld_s1) - 3'(pop);
	assign credit    = pending < 3'd2;
	assign issue     = (state_q == WALK_RUN) & credit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WALK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			WALK_IDLE: begin
				in_ready = 1'b1;
				if (read_acc && run_len != '0) begin
					state_d = WALK_RUN;
				end
			end
			WALK_RUN: begin
				if (issue && remain_q == READ_COUNT_W'(1)) begin
					state_d = WALK_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			remain_q  <= '0;
			rd_vld_s1 <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			if (read_acc) begin
				slot_q   <= newest_q;
				remain_q <= run_len;
			end else if (issue) begin
				slot_q   <= (slot_q == '0) ? SLOT_LAST : slot_q - 1'b1;
				remain_q <= remain_q - 1'b1;
			end
			rd_vld_s1 <= issue;
			last_s1   <= issue & (remain_q == READ_COUNT_W'(1));
		end
	end

	// ring memory
	assign ring_ctrl.wr_en   = store;
	assign ring_ctrl.wr_slot = next_slot;
	assign ring_ctrl.rd_en   = issue;
	assign ring_ctrl.rd_slot = slot_q;
	assign wr_entry.value    = sample;
	assign wr_entry.stamp    = sample_time;

	rfsh_ring u_ring (
		.clk      (clk),
		.ctrl     (ring_ctrl),
		.wr_entry (wr_entry),
		.rd_entry (rd_entry)
	);

	// output buffer
	assign pop       = out_valid & out_ready;
	assign out_valid = occ_q != 2'd0;

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			fifo_q[wr_ptr_q] <= '{entry: rd_entry, last: last_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			occ_q    <= 2'd0;
		end else begin
			if (rd_vld_s1) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			occ_q <= pending[1:0];
		end
	end

	assign stored_value = fifo_q[rd_ptr_q].entry.value;
	assign stored_time  = fifo_q[rd_ptr_q].entry.stamp;
	assign last_entry   = fifo_q[rd_ptr_q].last;

endmodule
`default_nettype wire

>>> src/rfsh_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfsh_checker
// Port-level checks of the range filtered sample history, bound to the
// top level.
// ----------------------------------------------------------------------------
module rfsh_checker
	import rfsh_pkg::*;
(
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_ready,
	input wire logic                      mode,
	input wire logic [READ_COUNT_W-1:0]   read_count,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic signed [VALUE_W-1:0] stored_value,
	input wire logic signed [TIME_W-1:0]  stored_time,
	input wire logic                      last_entry
);

	// a push transaction never closes the input channel
	a_push_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == MODE_PUSH |=> in_ready)
		else $error("input blocked after push");

	// a read asking for nothing leaves the block idle
	a_empty_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == MODE_READ && read_count == '0 |=> in_ready)
		else $error("input blocked after empty read");

	// stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn");

	// stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(stored_value) && $stable(stored_time)
		&& $stable(last_entry))
		else $error("result changed under stall");

endmodule

bind range_filtered_sample_history_top rfsh_checker u_rfsh_checker (.*);
`default_nettype wire
